// File: rtl/core/irdq_pkg.sv
// Shared request and status codes and controller/datapath link types for the deque.
package irdq_pkg;

   localparam int ValueW  = 32;
   localparam int ReqW    = 3;
   localparam int StatusW = 2;

   localparam logic [ReqW-1:0] REQ_INSERT_REAR  = 3'd0;
   localparam logic [ReqW-1:0] REQ_DELETE_FRONT = 3'd1;
   localparam logic [ReqW-1:0] REQ_DELETE_REAR  = 3'd2;
   localparam logic [ReqW-1:0] REQ_PEEK_FRONT   = 3'd3;
   localparam logic [ReqW-1:0] REQ_PEEK_REAR    = 3'd4;

   localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
   localparam logic [StatusW-1:0] STATUS_FULL  = 2'd1;
   localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch request and issue the slot read
      logic commit;    // apply the request and load the result register
   } irdq_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic is_empty;
      logic is_full;
   } irdq_stat_type;

endpackage

// File: rtl/core/irdq_ctrl.sv
// Request sequencer and result-valid control for the deque.
module irdq_ctrl
   import irdq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  irdq_stat_type stat,
   output irdq_cmd_type  cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic result_free;

   // The result register can take a new transaction once the old one leaves.
   assign result_free = !rsp_valid_ff || rsp_ready;

   assign req_ready   = (state_ff == S_IDLE);
   assign cmd.capture = req_valid && (state_ff == S_IDLE);
   assign cmd.commit  = (state_ff == S_EXEC) && result_free;
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.capture) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (cmd.commit) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Status is informational for the sequencer; fold it into nothing else.
   logic unused_stat;
   assign unused_stat = stat.is_empty ^ stat.is_full;

endmodule

// File: rtl/core/irdq_dpath.sv
// Slot memory, head/tail pointers, empty flag and result register of the deque.
module irdq_dpath
   import irdq_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  irdq_cmd_type              cmd,
   output irdq_stat_type             stat,
   input  logic [ReqW-1:0]           req_type,
   input  logic signed [ValueW-1:0]  req_push_value,
   output logic signed [ValueW-1:0]  rsp_item_value,
   output logic [StatusW-1:0]        rsp_status
);

   localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);

   logic [ValueW-1:0] mem [DEPTH];

   logic [ReqW-1:0]          req_type_ff;
   logic [ValueW-1:0]        push_value_ff;
   logic [ValueW-1:0]        rd_data_ff;
   logic [IdxW-1:0]          rd_addr;
   logic [IdxW-1:0]          head_ff, head_in;
   logic [IdxW-1:0]          tail_ff, tail_in;
   logic                     empty_ff, empty_in;
   logic signed [ValueW-1:0] item_ff, item_in;
   logic [StatusW-1:0]       status_ff, status_in;
   logic                     wr_en;
   logic [IdxW-1:0]          wr_addr;
   logic [IdxW-1:0]          tail_next, head_next, tail_prev;
   logic                     full;

   assign tail_next = (tail_ff == LastIdx) ? '0 : tail_ff + 1'b1;
   assign head_next = (head_ff == LastIdx) ? '0 : head_ff + 1'b1;
   assign tail_prev = (tail_ff == '0) ? LastIdx : tail_ff - 1'b1;
   assign full      = !empty_ff && (tail_next == head_ff);

   assign stat.is_empty = empty_ff;
   assign stat.is_full  = full;

   // Front requests read at head, rear requests at tail.
   always_comb begin
      case (req_type) inside
         REQ_DELETE_FRONT, REQ_PEEK_FRONT: rd_addr = head_ff;
         default:                          rd_addr = tail_ff;
      endcase
   end

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      empty_in  = empty_ff;
      item_in   = '0;
      status_in = STATUS_OK;
      wr_en     = 1'b0;
      wr_addr   = tail_next;
      unique case (req_type_ff) inside
         REQ_INSERT_REAR: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else if (empty_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b0;
               wr_en    = 1'b1;
               wr_addr  = '0;
            end else begin
               tail_in = tail_next;
               wr_en   = 1'b1;
            end
         end
         REQ_DELETE_FRONT: begin
            if (empty_ff) begin
               status_in = STATUS_EMPTY;
            end else begin
               item_in = rd_data_ff;
               if (head_ff == tail_ff) begin
                  empty_in = 1'b1;
                  head_in  = '0;
                  tail_in  = '0;
               end else begin
                  head_in = head_next;
               end
            end
         end
         REQ_DELETE_REAR: begin
            if (empty_ff) begin
               status_in = STATUS_EMPTY;
            end else begin
               item_in = rd_data_ff;
               if (head_ff == tail_ff) begin
                  empty_in = 1'b1;
                  head_in  = '0;
                  tail_in  = '0;
               end else begin
                  tail_in = tail_prev;
               end
            end
         end
         REQ_PEEK_FRONT, REQ_PEEK_REAR: begin
            if (empty_ff) begin
               status_in = STATUS_EMPTY;
            end else begin
               item_in = rd_data_ff;
            end
         end
         default: begin
            // unused codes: no state change, zero result
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff   <= req_type;
         push_value_ff <= req_push_value;
         rd_data_ff    <= mem[rd_addr];
      end
      if (cmd.commit && wr_en) begin
         mem[wr_addr] <= push_value_ff;
      end
      if (cmd.commit) begin
         item_ff   <= item_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
      end else if (cmd.commit) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
      end
   end

   assign rsp_item_value = item_ff;
   assign rsp_status     = status_ff;

endmodule

// File: rtl/core/input_restricted_deque_top.sv
// Top level of the input-restricted circular deque.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_type[2:0], req_push_value[31:0]
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_item_value[31:0], rsp_status[1:0]
//
// A request first gets the registered slot-memory read at head or tail, then the
// update step that moves the pointers, writes the slot and loads the result.
// The result register lets the next request be taken while a result waits;
// the update cycle then holds until the waiting result is taken.
// Reset empties the queue at once; slot contents stay undefined until written.
module input_restricted_deque_top
   import irdq_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [ReqW-1:0]           req_type,
   input  logic signed [ValueW-1:0]  req_push_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [ValueW-1:0]  rsp_item_value,
   output logic [StatusW-1:0]        rsp_status
);

   irdq_cmd_type  cmd;
   irdq_stat_type stat;

   irdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   irdq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_type       (req_type),
      .req_push_value (req_push_value),
      .rsp_item_value (rsp_item_value),
      .rsp_status     (rsp_status)
   );

   // A taken request blocks the input until it has been applied.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one still in flight");

   // Only defined status codes leave the block.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_FULL ||
                     rsp_status == STATUS_EMPTY))
      else $error("undefined status code on result");

   // Full or empty results carry no item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_item_value == '0)
      else $error("item returned with a failing status");

   // Full and empty never hold together.
   assert property (@(posedge clock) disable iff (reset)
      !(stat.is_full && stat.is_empty))
      else $error("queue flagged both full and empty");

endmodule

// File: bench/input_restricted_deque_top_tb.sv
// Self-checking bench for the input-restricted deque: driver, monitor and predictor.
`timescale 1ns / 100ps

module input_restricted_deque_top_tb;
   import irdq_pkg::*;

   localparam int DEPTH          = 16;
   localparam int IDLE_PCT       = 23;
   localparam int RANDOM_ITEMS   = 800;
   localparam int DRAIN_POINT    = 400;
   localparam int WATCHDOG_LIMIT = 500;
   localparam int TAIL_CYCLES    = 8;

   typedef struct {
      logic [ReqW-1:0]          kind;
      logic signed [ValueW-1:0] value;
      bit                       drain_first;
   } deque_req_type;

   typedef struct {
      logic signed [ValueW-1:0] item;
      logic [StatusW-1:0]       status;
   } deque_rsp_type;

   logic                      clock          = 1'b0;
   logic                      reset          = 1'b1;
   logic                      req_valid      = 1'b0;
   logic                      req_ready;
   logic [ReqW-1:0]           req_type       = REQ_INSERT_REAR;
   logic signed [ValueW-1:0]  req_push_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready      = 1'b0;
   logic signed [ValueW-1:0]  rsp_item_value;
   logic [StatusW-1:0]        rsp_status;

   deque_req_type pending_reqs[$];
   deque_rsp_type awaited_rsps[$];

   // shadow copy of the deque
   logic signed [ValueW-1:0] shadow_slots [DEPTH];
   int  shadow_head  = 0;
   int  shadow_tail  = 0;
   bit  shadow_empty = 1'b1;

   int  reqs_sent     = 0;
   int  rsps_seen     = 0;
   int  idle_cycles   = 0;
   int  errors        = 0;
   int  full_hits     = 0;
   int  empty_hits    = 0;
   int  rear_wraps    = 0;
   bit  timed_out     = 1'b0;

   input_restricted_deque_top #(.DEPTH(DEPTH)) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item_value (rsp_item_value),
      .rsp_status     (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int next_slot(input int idx);
      return (idx == DEPTH - 1) ? 0 : idx + 1;
   endfunction

   task automatic deque_predict(input logic [ReqW-1:0] kind,
                                input logic signed [ValueW-1:0] value,
                                output deque_rsp_type rsp);
      rsp.item   = '0;
      rsp.status = STATUS_OK;
      if (kind == REQ_INSERT_REAR) begin
         if (!shadow_empty && next_slot(shadow_tail) == shadow_head) begin
            rsp.status = STATUS_FULL;
            full_hits++;
         end else if (shadow_empty) begin
            shadow_head     = 0;
            shadow_tail     = 0;
            shadow_slots[0] = value;
            shadow_empty    = 1'b0;
         end else begin
            shadow_tail               = next_slot(shadow_tail);
            shadow_slots[shadow_tail] = value;
         end
      end else if (kind <= REQ_PEEK_REAR) begin
         if (shadow_empty) begin
            rsp.status = STATUS_EMPTY;
            empty_hits++;
         end else if (kind == REQ_DELETE_FRONT || kind == REQ_PEEK_FRONT) begin
            rsp.item = shadow_slots[shadow_head];
            if (kind == REQ_DELETE_FRONT) begin
               if (shadow_head == shadow_tail) begin
                  shadow_empty = 1'b1;
                  shadow_head  = 0;
                  shadow_tail  = 0;
               end else begin
                  shadow_head = next_slot(shadow_head);
               end
            end
         end else begin
            rsp.item = shadow_slots[shadow_tail];
            if (kind == REQ_DELETE_REAR) begin
               if (shadow_head == shadow_tail) begin
                  shadow_empty = 1'b1;
                  shadow_head  = 0;
                  shadow_tail  = 0;
               end else if (shadow_tail == 0) begin
                  shadow_tail = DEPTH - 1;
                  rear_wraps++;
               end else begin
                  shadow_tail = shadow_tail - 1;
               end
            end
         end
      end
   endtask

   task automatic add_req(input logic [ReqW-1:0] kind,
                          input logic signed [ValueW-1:0] value,
                          input bit drain_first = 1'b0);
      deque_req_type r;
      r.kind        = kind;
      r.value       = value;
      r.drain_first = drain_first;
      pending_reqs.push_back(r);
   endtask

   function automatic logic signed [ValueW-1:0] pick_value();
      case ($urandom_range(15))
         0:       return 32'sh7fff_ffff;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // insert_pct sets the insert share; a few unused codes are mixed in as noise
   function automatic logic [ReqW-1:0] pick_kind(input int insert_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < 5)
         return ReqW'($urandom_range(7, REQ_PEEK_REAR + 1));
      else if (roll < 5 + insert_pct)
         return REQ_INSERT_REAR;
      else
         return ReqW'($urandom_range(REQ_PEEK_REAR, REQ_DELETE_FRONT));
   endfunction

   // driver: hold each transaction until accepted, idle at random outside a no-idle window
   always @(posedge clock) begin : drive
      bit            launch;
      deque_req_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            reqs_sent++;
         if (!req_valid || req_ready) begin
            launch = pending_reqs.size() != 0 &&
                     ((reqs_sent >= 300 && reqs_sent < 450) ||
                      $urandom_range(99) >= IDLE_PCT);
            if (launch && pending_reqs[0].drain_first && reqs_sent != rsps_seen)
               launch = 1'b0;
            if (launch) begin
               next_req = pending_reqs.pop_front();
               req_type       <= next_req.kind;
               req_push_value <= next_req.value;
            end
            req_valid <= launch;
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= (rsps_seen >= 550 && rsps_seen < 700) ||
                      $urandom_range(99) >= IDLE_PCT;
   end

   // monitor: check the result first, then predict the new request
   always @(posedge clock) begin : monitor
      deque_rsp_type want;
      deque_rsp_type fresh;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsps.size() == 0) begin
               $error("unexpected result: item %0d status %0d", rsp_item_value, rsp_status);
               errors++;
            end else begin
               want = awaited_rsps.pop_front();
               if (rsp_item_value !== want.item) begin
                  $error("rsp_item_value: expected %0d, actual %0d", want.item, rsp_item_value);
                  errors++;
               end
               if (rsp_status !== want.status) begin
                  $error("rsp_status: expected %0d, actual %0d", want.status, rsp_status);
                  errors++;
               end
            end
            rsps_seen <= rsps_seen + 1;
         end
         if (req_valid && req_ready) begin
            deque_predict(req_type, req_push_value, fresh);
            awaited_rsps.push_back(fresh);
         end
         idle_cycles <= ((rsp_valid && rsp_ready) || (req_valid && req_ready)) ?
                        0 : idle_cycles + 1;
      end
   end

   initial begin
      int  burst_len;
      bit  drain_placed;
      drain_placed = 1'b0;

      // empty queue: every read-side request and the unused codes
      add_req(REQ_PEEK_FRONT, '0);
      add_req(REQ_PEEK_REAR, '0);
      add_req(REQ_DELETE_FRONT, '0);
      add_req(REQ_DELETE_REAR, '0);
      add_req(ReqW'(REQ_PEEK_REAR + 1), -32'sd1);
      add_req(ReqW'(REQ_PEEK_REAR + 2), '0);
      add_req(ReqW'(REQ_PEEK_REAR + 3), 32'sh8000_0000);
      // single item, removed from the rear
      add_req(REQ_INSERT_REAR, 32'sh7fff_ffff);
      add_req(REQ_PEEK_FRONT, '0);
      add_req(REQ_PEEK_REAR, '0);
      add_req(REQ_DELETE_REAR, '0);
      // extremes, front removals, then drain from the rear
      add_req(REQ_INSERT_REAR, 32'sh8000_0000);
      add_req(REQ_INSERT_REAR, -32'sd1);
      add_req(REQ_INSERT_REAR, '0);
      add_req(REQ_DELETE_FRONT, 32'sh7fff_ffff);
      add_req(REQ_DELETE_FRONT, '0);
      add_req(REQ_INSERT_REAR, 32'sh5555_5555);
      add_req(REQ_DELETE_REAR, '0);
      add_req(REQ_DELETE_REAR, '0);
      add_req(REQ_PEEK_FRONT, '0);

      // fill to capacity, overflow, then wrap the tail through slot zero
      for (int i = 0; i < DEPTH + 1; i++)
         add_req(REQ_INSERT_REAR, pick_value());
      add_req(REQ_DELETE_FRONT, '0);
      add_req(REQ_INSERT_REAR, pick_value());
      add_req(REQ_DELETE_REAR, '0);
      add_req(REQ_PEEK_REAR, '0);
      add_req(REQ_PEEK_FRONT, '0);

      while (pending_reqs.size() < RANDOM_ITEMS + 20) begin
         burst_len = $urandom_range(12, 24);
         case ($urandom_range(3))
            0: for (int i = 0; i < burst_len; i++)
                  add_req(pick_kind(85), pick_value());
            1: for (int i = 0; i < burst_len; i++)
                  add_req(pick_kind(10), pick_value());
            2: for (int i = 0; i < burst_len; i++)
                  add_req(pick_kind(45), pick_value());
            default: for (int i = 0; i < burst_len; i++)
                  add_req((i % 2 == 0) ? REQ_INSERT_REAR : REQ_DELETE_FRONT, pick_value());
         endcase
         // drop the sender back until the deque has answered everything
         if (!drain_placed && pending_reqs.size() > DRAIN_POINT) begin
            add_req(pick_kind(45), pick_value(), 1'b1);
            drain_placed = 1'b1;
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (!timed_out &&
             !(pending_reqs.size() == 0 && !req_valid && awaited_rsps.size() == 0)) begin
         @(negedge clock);
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            timed_out = 1'b1;
            $error("watchdog: no transaction for %0d cycles, %0d results outstanding",
                   idle_cycles, awaited_rsps.size());
         end
      end

      if (!timed_out) begin
         repeat (TAIL_CYCLES) @(negedge clock);
         $display("tb: %0d requests, %0d results checked", reqs_sent, rsps_seen);
         $display("tb: full %0d, empty %0d, rear wraps at slot zero %0d",
                  full_hits, empty_hits, rear_wraps);
      end

      if (!timed_out && errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
